### design/rcfp_pkg.sv
// ----------------------------------------------------------------------------
// rcfp_pkg
// Types, codes and helpers shared by the radio control frame parser.
// ----------------------------------------------------------------------------
package rcfp_pkg;

	localparam int FREQ_BCD_BYTES_DEF = 5;
	localparam int FREQ_W             = 34;
	localparam int HDR_LEN            = 5;
	localparam int REG_ADDR_W         = 3;
	localparam int REG_DATA_W         = 32;

	localparam logic [7:0] PREAMBLE   = 8'hFE;
	localparam logic [7:0] CMD_FREQ   = 8'h03;
	localparam logic [7:0] CMD_MODE   = 8'h01;
	localparam logic [7:0] CMD_LEVEL  = 8'h15;
	localparam logic [3:0] NIBBLE_MSK = 4'h0F;

	localparam logic [0:0] REG_DIGIT_ORDER = 1'b0;

	localparam logic [2:0] ST_SHORT      = 3'd0;
	localparam logic [2:0] ST_BAD_PRE    = 3'd1;
	localparam logic [2:0] ST_FREQ_SET   = 3'd2;
	localparam logic [2:0] ST_FREQ_SHORT = 3'd3;
	localparam logic [2:0] ST_MODE_SET   = 3'd4;
	localparam logic [2:0] ST_LEVEL_SET  = 3'd5;
	localparam logic [2:0] ST_EMPTY      = 3'd6;
	localparam logic [2:0] ST_IGNORED    = 3'd7;

	localparam logic [2:0] MODE_UNKNOWN = 3'd0;
	localparam logic [2:0] MODE_LSB     = 3'd1;
	localparam logic [2:0] MODE_USB     = 3'd2;
	localparam logic [2:0] MODE_AM      = 3'd3;
	localparam logic [2:0] MODE_FM      = 3'd4;
	localparam logic [2:0] MODE_CW      = 3'd5;
	localparam logic [2:0] MODE_MAX     = MODE_CW;

	localparam logic [7:0] RADIO_LSB = 8'h00;
	localparam logic [7:0] RADIO_USB = 8'h01;
	localparam logic [7:0] RADIO_AM  = 8'h02;
	localparam logic [7:0] RADIO_FM  = 8'h03;
	localparam logic [7:0] RADIO_CW  = 8'h05;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       end_of_frame;
	} in_t;

	typedef struct packed {
		logic [FREQ_W-1:0] frequency_hz;
		logic [2:0]        mode_code;
		logic [7:0]        signal_level;
		logic [2:0]        frame_status;
	} out_t;

	function automatic logic [2:0] map_mode(input logic [7:0] m);
		logic [2:0] r;
		unique case (m)
			RADIO_LSB: r = MODE_LSB;
			RADIO_USB: r = MODE_USB;
			RADIO_AM:  r = MODE_AM;
			RADIO_FM:  r = MODE_FM;
			RADIO_CW:  r = MODE_CW;
			default:   r = MODE_UNKNOWN;
		endcase
		return r;
	endfunction

	function automatic logic [FREQ_W-1:0] mul100(input logic [FREQ_W-1:0] x);
		return (x << 6) + (x << 5) + (x << 2);
	endfunction

	// two packed digits to their value, nibbles above nine taken as given
	function automatic logic [7:0] byte_value(input logic [7:0] b);
		logic [7:0] hi;
		logic [7:0] lo;
		hi = {4'b0, b[7:4] & NIBBLE_MSK};
		lo = {4'b0, b[3:0] & NIBBLE_MSK};
		return (hi << 3) + (hi << 1) + lo;
	endfunction

endpackage

### design/radio_control_frame_parser.sv
// ----------------------------------------------------------------------------
// radio_control_frame_parser
// Parses radio control frames byte by byte and gives one result per frame.
// ----------------------------------------------------------------------------
// Bytes enter on the item channel (valid/ready), one per transaction, the last
// byte of a frame flagged by end_of_frame. Each frame's last byte yields one
// result transaction carrying the kept frequency, mode and signal level after
// the frame was applied, plus a status code.
// The result is registered and valid in the cycle after the last byte is accepted.
// Throughput: one byte per cycle while item_ready is high. The frequency grows
// as the payload arrives: a multiply-by-100 accumulator (MSB first) and a sum
// with running power-of-100 weights (LSB first), so the end needs an add, a select.
// The result register frees item_ready whenever it is empty or being taken;
// when the receiver stalls with a result held, item_ready drops until the
// result is taken.
// Reset clears the kept values, the frame position and the digit order
// register. The configuration port is APB-style with pready tied high;
// digit_order lies at byte address 0.
// ----------------------------------------------------------------------------
module radio_control_frame_parser #(
	parameter int FREQ_BCD_BYTES = rcfp_pkg::FREQ_BCD_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  rcfp_pkg::in_t                     item,
	output logic                              result_valid,
	input  logic                              result_ready,
	output rcfp_pkg::out_t                    result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rcfp_pkg::REG_ADDR_W-1:0]   paddr,
	input  logic [rcfp_pkg::REG_DATA_W-1:0]   pwdata,
	output logic [rcfp_pkg::REG_DATA_W-1:0]   prdata,
	output logic                              pready
);

	localparam int POS_LIMIT = rcfp_pkg::HDR_LEN + FREQ_BCD_BYTES;
	localparam int POS_W     = $clog2(POS_LIMIT + 1);
	localparam int FW        = rcfp_pkg::FREQ_W;

	localparam logic [POS_W-1:0] P_PRE1  = POS_W'(1);
	localparam logic [POS_W-1:0] P_CMD   = POS_W'(4);
	localparam logic [POS_W-1:0] P_PAY0  = POS_W'(rcfp_pkg::HDR_LEN);
	localparam logic [POS_W-1:0] P_LIMIT = POS_W'(POS_LIMIT);

	logic             digit_order_q;
	logic [POS_W-1:0] pos_q;
	logic             pre_good_q;
	logic [7:0]       cmd_q;
	logic [7:0]       first_q;
	logic [FW-1:0]    acc_msb_q;
	logic [FW-1:0]    acc_lsb_q;
	logic [FW-1:0]    weight_q;
	logic [FW-1:0]    kept_freq_q;
	logic [2:0]       kept_mode_q;
	logic [7:0]       kept_level_q;
	logic             result_valid_q;
	rcfp_pkg::out_t   result_q;

	logic             accept;
	logic             cfg_write;
	logic [7:0]       b;
	logic [7:0]       bv;
	logic             store;
	logic             first_pay;
	logic [POS_W-1:0] pos_n;
	logic             pre_good_n;
	logic [7:0]       cmd_n;
	logic [7:0]       first_n;
	logic [FW-1:0]    msb_base;
	logic [FW-1:0]    lsb_base;
	logic [FW-1:0]    w_base;
	logic [FW+7:0]    prod;
	logic [FW-1:0]    acc_msb_n;
	logic [FW-1:0]    acc_lsb_n;
	logic [FW-1:0]    weight_n;
	logic [2:0]       status_n;
	logic [FW-1:0]    freq_n;
	logic [2:0]       mode_n;
	logic [7:0]       level_n;

	assign item_ready   = !result_valid_q || result_ready;
	assign accept       = item_valid && item_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign pready       = 1'b1;
	assign cfg_write    = psel && penable && pwrite
		&& (paddr[2] == rcfp_pkg::REG_DIGIT_ORDER);

	always_comb begin
		prdata = '0;
		if (paddr[2] == rcfp_pkg::REG_DIGIT_ORDER) begin
			prdata[0] = digit_order_q;
		end
	end

	assign b         = item.frame_byte;
	assign bv        = rcfp_pkg::byte_value(b);
	assign store     = (pos_q >= P_PAY0) && (pos_q < P_LIMIT);
	assign first_pay = (pos_q == P_PAY0);

	assign msb_base  = first_pay ? '0 : acc_msb_q;
	assign lsb_base  = first_pay ? '0 : acc_lsb_q;
	assign w_base    = first_pay ? FW'(1) : weight_q;
	assign prod      = bv * w_base;
	assign acc_msb_n = store ? rcfp_pkg::mul100(msb_base) + FW'(bv) : acc_msb_q;
	assign acc_lsb_n = store ? lsb_base + prod[FW-1:0] : acc_lsb_q;
	assign weight_n  = store ? rcfp_pkg::mul100(w_base) : weight_q;

	assign pre_good_n = pre_good_q && !((pos_q <= P_PRE1) && (b != rcfp_pkg::PREAMBLE));
	assign cmd_n      = (pos_q == P_CMD) ? b : cmd_q;
	assign first_n    = first_pay ? b : first_q;
	assign pos_n      = (pos_q < P_LIMIT) ? pos_q + POS_W'(1) : P_LIMIT;

	always_comb begin
		status_n = rcfp_pkg::ST_IGNORED;
		freq_n   = kept_freq_q;
		mode_n   = kept_mode_q;
		level_n  = kept_level_q;
		if (pos_n < P_PAY0) begin
			status_n = rcfp_pkg::ST_SHORT;
		end else if (!pre_good_n) begin
			status_n = rcfp_pkg::ST_BAD_PRE;
		end else begin
			case (cmd_n)
				rcfp_pkg::CMD_FREQ: begin
					if (pos_n == P_LIMIT) begin
						status_n = rcfp_pkg::ST_FREQ_SET;
						freq_n   = digit_order_q ? acc_lsb_n : acc_msb_n;
					end else begin
						status_n = rcfp_pkg::ST_FREQ_SHORT;
					end
				end
				rcfp_pkg::CMD_MODE: begin
					if (pos_n == P_PAY0) begin
						status_n = rcfp_pkg::ST_EMPTY;
					end else begin
						status_n = rcfp_pkg::ST_MODE_SET;
						mode_n   = rcfp_pkg::map_mode(first_n);
					end
				end
				rcfp_pkg::CMD_LEVEL: begin
					if (pos_n == P_PAY0) begin
						status_n = rcfp_pkg::ST_EMPTY;
					end else begin
						status_n = rcfp_pkg::ST_LEVEL_SET;
						level_n  = first_n;
					end
				end
				default: status_n = rcfp_pkg::ST_IGNORED;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_order_q  <= 1'b0;
			pos_q          <= '0;
			pre_good_q     <= 1'b1;
			cmd_q          <= '0;
			kept_freq_q    <= '0;
			kept_mode_q    <= rcfp_pkg::MODE_UNKNOWN;
			kept_level_q   <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				digit_order_q <= pwdata[0];
			end
			if (accept && item.end_of_frame) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (accept) begin
				cmd_q <= cmd_n;
				if (item.end_of_frame) begin
					pos_q        <= '0;
					pre_good_q   <= 1'b1;
					kept_freq_q  <= freq_n;
					kept_mode_q  <= mode_n;
					kept_level_q <= level_n;
				end else begin
					pos_q      <= pos_n;
					pre_good_q <= pre_good_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_q   <= first_n;
			acc_msb_q <= acc_msb_n;
			acc_lsb_q <= acc_lsb_n;
			weight_q  <= weight_n;
			if (item.end_of_frame) begin
				result_q.frequency_hz <= freq_n;
				result_q.mode_code    <= mode_n;
				result_q.signal_level <= level_n;
				result_q.frame_status <= status_n;
			end
		end
	end

	a_eof_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.end_of_frame |=> result_valid)
		else $error("frame end without result");

	a_eof_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.end_of_frame |=> pos_q == '0 && pre_good_q)
		else $error("frame position not rewound");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= P_LIMIT)
		else $error("frame position beyond limit");

	a_mid_byte_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !item.end_of_frame && !result_valid |=> !result_valid)
		else $error("result from a mid-frame byte");

	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.mode_code <= rcfp_pkg::MODE_MAX)
		else $error("mode code out of range");

endmodule

### verif/radio_control_frame_parser_tb.sv
// ----------------------------------------------------------------------------
// radio_control_frame_parser_tb
// Self-checking bench for the radio control frame parser.
// ----------------------------------------------------------------------------
// Frames are queued byte by byte and sent on the item channel by a clocked
// driver. A clocked monitor runs each accepted byte through a frame tracker
// of its own, which keeps the expected frequency, mode, level and status for
// every frame end. Each result transaction is checked against them in order.
// A short directed run precedes three random runs (digit order 1, 0, 1).
// Each random run has its own pattern of sender and receiver stalls.
// ----------------------------------------------------------------------------
module radio_control_frame_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NB          = rcfp_pkg::FREQ_BCD_BYTES_DEF;
	localparam int RUN_BYTES   = 250;
	localparam int CYCLE_LIMIT = 200000;

	localparam logic [0:0] REG_SPARE = 1'b1;
	localparam logic [rcfp_pkg::REG_ADDR_W-1:0] ADDR_ORDER =
		{rcfp_pkg::REG_DIGIT_ORDER, 2'b00};
	localparam logic [rcfp_pkg::REG_ADDR_W-1:0] ADDR_SPARE = {REG_SPARE, 2'b00};

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            item_valid = 1'b0;
	logic                            item_ready;
	rcfp_pkg::in_t                   item = '0;
	logic                            result_valid;
	logic                            result_ready = 1'b0;
	rcfp_pkg::out_t                  result;
	logic                            psel = 1'b0;
	logic                            penable = 1'b0;
	logic                            pwrite = 1'b0;
	logic [rcfp_pkg::REG_ADDR_W-1:0] paddr = '0;
	logic [rcfp_pkg::REG_DATA_W-1:0] pwdata = '0;
	logic [rcfp_pkg::REG_DATA_W-1:0] prdata;
	logic                            pready;

	rcfp_pkg::in_t  rx_bytes[$];
	logic [7:0]     frame_buf[$];
	rcfp_pkg::out_t frame_results[$];
	int             queued_bytes = 0;
	int             err_count = 0;
	int             cycles = 0;
	int             send_idle_pct = 0;
	int             recv_idle_pct = 0;

	logic [3:0]                  pos_q = '0;
	logic                        pre_ok = 1'b1;
	logic [7:0]                  cmd_q = '0;
	logic [7:0]                  pay_q [NB];
	logic [rcfp_pkg::FREQ_W-1:0] freq_q = '0;
	logic [2:0]                  mode_q = rcfp_pkg::MODE_UNKNOWN;
	logic [7:0]                  level_q = '0;
	logic                        order_q = 1'b0;

	radio_control_frame_parser u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic track_frame_byte(input rcfp_pkg::in_t it);
		rcfp_pkg::out_t r;
		logic [63:0]    acc;
		logic [3:0]     p;
		logic [2:0]     st;
		int             k;
		p = pos_q;
		if (p < 2 && it.frame_byte != rcfp_pkg::PREAMBLE) pre_ok = 1'b0;
		if (p == 4) cmd_q = it.frame_byte;
		if (p >= rcfp_pkg::HDR_LEN && p < rcfp_pkg::HDR_LEN + NB)
			pay_q[p - rcfp_pkg::HDR_LEN] = it.frame_byte;
		if (p < rcfp_pkg::HDR_LEN + NB) p++;
		pos_q = p;
		if (it.end_of_frame) begin
			if (p < rcfp_pkg::HDR_LEN) begin
				st = rcfp_pkg::ST_SHORT;
			end else if (!pre_ok) begin
				st = rcfp_pkg::ST_BAD_PRE;
			end else begin
				case (cmd_q)
					rcfp_pkg::CMD_FREQ: begin
						if (p < rcfp_pkg::HDR_LEN + NB) begin
							st = rcfp_pkg::ST_FREQ_SHORT;
						end else begin
							acc = '0;
							for (int i = 0; i < NB; i++) begin
								k = order_q ? NB - 1 - i : i;
								acc = acc * 10 + 64'(pay_q[k][7:4]);
								acc = acc * 10 + 64'(pay_q[k][3:0]);
							end
							freq_q = acc[rcfp_pkg::FREQ_W-1:0];
							st = rcfp_pkg::ST_FREQ_SET;
						end
					end
					rcfp_pkg::CMD_MODE: begin
						if (p == rcfp_pkg::HDR_LEN) begin
							st = rcfp_pkg::ST_EMPTY;
						end else begin
							case (pay_q[0])
								rcfp_pkg::RADIO_LSB: mode_q = rcfp_pkg::MODE_LSB;
								rcfp_pkg::RADIO_USB: mode_q = rcfp_pkg::MODE_USB;
								rcfp_pkg::RADIO_AM:  mode_q = rcfp_pkg::MODE_AM;
								rcfp_pkg::RADIO_FM:  mode_q = rcfp_pkg::MODE_FM;
								rcfp_pkg::RADIO_CW:  mode_q = rcfp_pkg::MODE_CW;
								default:             mode_q = rcfp_pkg::MODE_UNKNOWN;
							endcase
							st = rcfp_pkg::ST_MODE_SET;
						end
					end
					rcfp_pkg::CMD_LEVEL: begin
						if (p == rcfp_pkg::HDR_LEN) begin
							st = rcfp_pkg::ST_EMPTY;
						end else begin
							level_q = pay_q[0];
							st = rcfp_pkg::ST_LEVEL_SET;
						end
					end
					default: st = rcfp_pkg::ST_IGNORED;
				endcase
			end
			pos_q = '0;
			pre_ok = 1'b1;
			r.frequency_hz = freq_q;
			r.mode_code = mode_q;
			r.signal_level = level_q;
			r.frame_status = st;
			frame_results.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
		end else if (!item_valid || item_ready) begin
			if (rx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item <= rx_bytes.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin : monitor
		rcfp_pkg::out_t want;
		if (arst_n) begin
			if (item_valid && item_ready) track_frame_byte(item);
			if (result_valid && result_ready) begin
				if (frame_results.size() == 0) begin
					$error("result transaction with no frame end pending");
					err_count++;
				end else begin
					want = frame_results.pop_front();
					if (result.frequency_hz !== want.frequency_hz) begin
						$error("frequency_hz: expected %0d, got %0d",
							want.frequency_hz, result.frequency_hz);
						err_count++;
					end
					if (result.mode_code !== want.mode_code) begin
						$error("mode_code: expected %0d, got %0d",
							want.mode_code, result.mode_code);
						err_count++;
					end
					if (result.signal_level !== want.signal_level) begin
						$error("signal_level: expected %0d, got %0d",
							want.signal_level, result.signal_level);
						err_count++;
					end
					if (result.frame_status !== want.frame_status) begin
						$error("frame_status: expected %0d, got %0d",
							want.frame_status, result.frame_status);
						err_count++;
					end
				end
			end
		end
	end

	task automatic cfg_write(input logic [rcfp_pkg::REG_ADDR_W-1:0] addr,
			input logic [rcfp_pkg::REG_DATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_ORDER) order_q = data[0];
		@(posedge clk);
		psel <= 1'b1;
		paddr <= ADDR_ORDER;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[0] !== order_q) begin
			$error("digit_order: expected %0d, got %0d", order_q, prdata[0]);
			err_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_frame();
		rcfp_pkg::in_t it;
		foreach (frame_buf[i]) begin
			it.frame_byte = frame_buf[i];
			it.end_of_frame = (i == frame_buf.size() - 1);
			rx_bytes.push_back(it);
		end
		queued_bytes += frame_buf.size();
		frame_buf.delete();
	endtask

	task automatic open_frame(input logic [7:0] cmd);
		frame_buf.push_back(rcfp_pkg::PREAMBLE);
		frame_buf.push_back(rcfp_pkg::PREAMBLE);
		frame_buf.push_back(8'($urandom));
		frame_buf.push_back(8'($urandom));
		frame_buf.push_back(cmd);
	endtask

	function automatic logic [7:0] bcd_byte();
		if ($urandom_range(9) < 8) return {4'($urandom_range(9)), 4'($urandom_range(9))};
		return 8'($urandom);
	endfunction

	task automatic random_frame();
		int         kind;
		int         sel;
		int         n;
		logic [7:0] cmd;
		logic [7:0] m;
		kind = $urandom_range(99);
		if (kind < 15) begin
			n = $urandom_range(12, 1);
			repeat (n) frame_buf.push_back(8'($urandom));
		end else begin
			sel = $urandom_range(9);
			if (sel < 4) cmd = rcfp_pkg::CMD_FREQ;
			else if (sel < 6) cmd = rcfp_pkg::CMD_MODE;
			else if (sel < 8) cmd = rcfp_pkg::CMD_LEVEL;
			else cmd = 8'($urandom);
			open_frame(cmd);
			if (kind < 27) frame_buf[$urandom_range(1)] = 8'($urandom);
			if (cmd == rcfp_pkg::CMD_FREQ)
				n = ($urandom_range(9) < 7) ? NB : $urandom_range(NB + 3);
			else n = ($urandom_range(9) < 7) ? 1 : $urandom_range(3);
			repeat (n) begin
				if (cmd == rcfp_pkg::CMD_FREQ) begin
					frame_buf.push_back(bcd_byte());
				end else if (cmd == rcfp_pkg::CMD_MODE && $urandom_range(3) != 0) begin
					case ($urandom_range(4))
						0:       m = rcfp_pkg::RADIO_LSB;
						1:       m = rcfp_pkg::RADIO_USB;
						2:       m = rcfp_pkg::RADIO_AM;
						3:       m = rcfp_pkg::RADIO_FM;
						default: m = rcfp_pkg::RADIO_CW;
					endcase
					frame_buf.push_back(m);
				end else begin
					frame_buf.push_back(8'($urandom));
				end
			end
		end
		send_frame();
	endtask

	task automatic drain();
		while (rx_bytes.size() != 0 || item_valid || frame_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int start;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 22;
		recv_idle_pct = 82;
		cfg_write(ADDR_SPARE, 32'd1);

		frame_buf.push_back(rcfp_pkg::PREAMBLE);
		send_frame();
		frame_buf.push_back(8'h00);
		frame_buf.push_back(rcfp_pkg::PREAMBLE);
		frame_buf.push_back(8'h00);
		frame_buf.push_back(8'h00);
		frame_buf.push_back(rcfp_pkg::CMD_FREQ);
		send_frame();
		open_frame(rcfp_pkg::CMD_FREQ);
		repeat (NB) frame_buf.push_back(8'h99);
		send_frame();
		open_frame(rcfp_pkg::CMD_FREQ);
		repeat (NB) frame_buf.push_back(8'hFF);
		frame_buf.push_back(8'h12);
		send_frame();
		open_frame(rcfp_pkg::CMD_MODE);
		frame_buf.push_back(rcfp_pkg::RADIO_CW);
		send_frame();
		open_frame(rcfp_pkg::CMD_LEVEL);
		send_frame();
		open_frame(8'h00);
		send_frame();
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 22;
					recv_idle_pct = 82;
				end
				1: begin
					send_idle_pct = 82;
					recv_idle_pct = 22;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			cfg_write(ADDR_ORDER, (ph == 1) ? 32'd0 : 32'd1);
			start = queued_bytes;
			while (queued_bytes - start < RUN_BYTES) random_frame();
			drain();
		end

		if (err_count == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule
